/* sv/assert_macros.svh */
// Assertion helpers included by the inference engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

/* sv/mlp_pkg.sv */
package mlp_pkg;
    typedef enum logic [2:0] {
        ACT_WEIGHT   = 3'd0,
        ACT_BIAS     = 3'd1,
        ACT_IN_NORM  = 3'd2,
        ACT_OUT_NORM = 3'd3,
        ACT_RANGE    = 3'd4,
        ACT_SAMPLE   = 3'd5
    } t_action;

    localparam logic [1:0] CFG_LAYERS  = 2'd0;
    localparam logic [1:0] CFG_INPUTS  = 2'd1;
    localparam logic [1:0] CFG_HIDDEN  = 2'd2;
    localparam logic [1:0] CFG_OUTPUTS = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic [1:0]         layer_sel;
        logic [4:0]         row_sel;
        logic [4:0]         col_sel;
        logic signed [31:0] value;
        logic signed [31:0] second_value;
        logic               sample_last;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         out_index;
        logic signed [31:0] out_value;
        logic               out_last;
    } t_out_item;

    // tanh samples in Q16 at steps of 0.25 on [0, 4]
    function automatic logic [16:0] tanh_point(input logic [4:0] idx);
        logic [16:0] r;
        begin
            case (idx)
                5'd0:  r = 17'd0;
                5'd1:  r = 17'd16051;
                5'd2:  r = 17'd30285;
                5'd3:  r = 17'd41625;
                5'd4:  r = 17'd49912;
                5'd5:  r = 17'd55593;
                5'd6:  r = 17'd59320;
                5'd7:  r = 17'd61694;
                5'd8:  r = 17'd63178;
                5'd9:  r = 17'd64096;
                5'd10: r = 17'd64659;
                5'd11: r = 17'd65000;
                5'd12: r = 17'd65212;
                5'd13: r = 17'd65339;
                5'd14: r = 17'd65417;
                5'd15: r = 17'd65464;
                default: r = 17'd65492;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat64to32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            else if (v < -64'sd2147483648) return 32'sh80000000;
            else return v[31:0];
        end
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [63:0] s;
        begin
            s = a + b;
            if (!a[63] && !b[63] && s[63]) return 64'sh7FFFFFFFFFFFFFFF;
            else if (a[63] && b[63] && !s[63]) return 64'sh8000000000000000;
            else return s;
        end
    endfunction
endpackage

/* sv/mlp_if.sv */
interface mlp_in_if;
    import mlp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mlp_out_if;
    import mlp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/mlp_ram.sv */
module mlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/mlp_inference_engine.sv */
// Fully connected network engine, Q16.16 (FRAC_BITS fraction bits).
// Load transactions (weight, bias, norm, range) are written as they are
// accepted. A sample transaction holds the input through four steps: norm
// read, subtract, multiply, store. A sample marked last starts the inference,
// which runs every weight product through one multiply-accumulate pipeline
// and the weight memory's single read port: each output unit accumulates its
// inputs, then drains the pipeline, adds the bias and applies the activation.
// Each result is then rescaled (source/range/norm read, span, two multiplies,
// send), and the rescale waits while a result is still pending. Input is not
// accepted from the start of a sample until its normalized value is stored or,
// for a last sample, until the last result of the inference is registered on
// the output.
`include "assert_macros.svh"
module mlp_inference_engine #(
    parameter int MAX_LAYERS  = 4,
    parameter int MAX_INPUTS  = 16,
    parameter int MAX_HIDDEN  = 32,
    parameter int MAX_OUTPUTS = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlp_in_if.sink      in_ch,
    mlp_out_if.source   out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    import mlp_pkg::*;

    localparam int ROW_SPAN  = (MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS;
    localparam int COL_SPAN  = (MAX_HIDDEN > MAX_INPUTS) ? MAX_HIDDEN : MAX_INPUTS;
    localparam int ACT_SPAN  = (ROW_SPAN > COL_SPAN) ? ROW_SPAN : COL_SPAN;
    localparam int NORM_SPAN = MAX_INPUTS + MAX_OUTPUTS;
    localparam int AW = (ACT_SPAN > 1) ? $clog2(ACT_SPAN) : 1;
    localparam int NW = (NORM_SPAN > 1) ? $clog2(NORM_SPAN) : 1;
    localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int WDEPTH = MAX_LAYERS * ROW_SPAN * COL_SPAN;
    localparam int BDEPTH = MAX_LAYERS * ROW_SPAN;
    localparam int WAW = $clog2(WDEPTH);
    localparam int BAW = $clog2(BDEPTH);
    localparam int CNTW = $clog2(ACT_SPAN + 1);
    localparam int LCW  = $clog2(MAX_LAYERS + 1);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SRD    = 14'b00000000000010,
        S_SSUB   = 14'b00000000000100,
        S_SMUL   = 14'b00000000001000,
        S_SWR    = 14'b00000000010000,
        S_MAC    = 14'b00000000100000,
        S_MDRAIN = 14'b00000001000000,
        S_BIAS   = 14'b00000010000000,
        S_ACT    = 14'b00000100000000,
        S_ORD    = 14'b00001000000000,
        S_OSPAN  = 14'b00010000000000,
        S_OMUL1  = 14'b00100000000000,
        S_OMUL2  = 14'b01000000000000,
        S_OSEND  = 14'b10000000000000
    } t_state;

    t_state r_state;

    // configuration, clamped on use
    logic [2:0] r_cfg_layers;
    logic [4:0] r_cfg_inputs;
    logic [5:0] r_cfg_hidden;
    logic [3:0] r_cfg_outputs;
    logic [LCW-1:0]  nl;
    logic [CNTW-1:0] ni, nh, no;

    always_comb begin
        nl = (r_cfg_layers == 3'd0) ? LCW'(1) :
             (32'(r_cfg_layers) > MAX_LAYERS) ? LCW'(MAX_LAYERS) : LCW'(r_cfg_layers);
        ni = (r_cfg_inputs == 5'd0) ? CNTW'(1) :
             (32'(r_cfg_inputs) > MAX_INPUTS) ? CNTW'(MAX_INPUTS) : CNTW'(r_cfg_inputs);
        nh = (r_cfg_hidden == 6'd0) ? CNTW'(1) :
             (32'(r_cfg_hidden) > MAX_HIDDEN) ? CNTW'(MAX_HIDDEN) : CNTW'(r_cfg_hidden);
        no = (r_cfg_outputs == 4'd0) ? CNTW'(1) :
             (32'(r_cfg_outputs) > MAX_OUTPUTS) ? CNTW'(MAX_OUTPUTS) : CNTW'(r_cfg_outputs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_layers  <= 3'd1;
            r_cfg_inputs  <= 5'(MAX_INPUTS);
            r_cfg_hidden  <= 6'(MAX_HIDDEN);
            r_cfg_outputs <= 4'(MAX_OUTPUTS);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LAYERS:  r_cfg_layers  <= i_cfg_data[2:0];
                CFG_INPUTS:  r_cfg_inputs  <= i_cfg_data[4:0];
                CFG_HIDDEN:  r_cfg_hidden  <= i_cfg_data[5:0];
                CFG_OUTPUTS: r_cfg_outputs <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // registers
    t_in_item r_item;
    logic [CNTW-1:0] r_sample_count;
    logic [LCW-1:0]  r_layer;
    logic [CNTW-1:0] r_unit, r_col, r_n_in, r_n_out;
    logic            r_src_b;     // source buffer is B
    logic            r_mac_v;     // product pipeline valid
    logic            r_mac_v2;
    logic signed [63:0] r_prod, r_acc;
    logic signed [31:0] r_res, r_span, r_v;
    logic signed [63:0] r_wide;
    logic            r_out_valid;
    t_out_item       r_out;

    wire in_acc = in_ch.valid && in_ch.ready;
    wire out_acc = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);

    wire t_action a_act = t_action'(in_ch.data.action);

    // memories
    logic           w_we, b_we, n_we, rg_we, aa_we, ab_we;
    logic [WAW-1:0] w_wa, w_ra;
    logic [BAW-1:0] b_wa, b_ra;
    logic [NW-1:0]  n_wa, n_ra;
    logic [OW-1:0]  rg_wa, rg_ra;
    logic [AW-1:0]  a_wa, a_ra;
    logic [31:0]    a_wd;
    logic [31:0]    w_rd, b_rd, aa_rd, ab_rd;
    logic [63:0]    n_rd, rg_rd;

    mlp_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_wmem (.i_clk, .i_we(w_we), .i_waddr(w_wa),
        .i_wdata(in_ch.data.value), .i_raddr(w_ra), .o_rdata(w_rd));
    mlp_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_bmem (.i_clk, .i_we(b_we), .i_waddr(b_wa),
        .i_wdata(in_ch.data.value), .i_raddr(b_ra), .o_rdata(b_rd));
    mlp_ram #(.WIDTH(64), .DEPTH(NORM_SPAN)) u_nmem (.i_clk, .i_we(n_we), .i_waddr(n_wa),
        .i_wdata({in_ch.data.value, in_ch.data.second_value}), .i_raddr(n_ra),
        .o_rdata(n_rd));
    mlp_ram #(.WIDTH(64), .DEPTH(MAX_OUTPUTS)) u_rmem (.i_clk, .i_we(rg_we), .i_waddr(rg_wa),
        .i_wdata({in_ch.data.value, in_ch.data.second_value}), .i_raddr(rg_ra),
        .o_rdata(rg_rd));
    mlp_ram #(.WIDTH(32), .DEPTH(ACT_SPAN)) u_amem (.i_clk, .i_we(aa_we), .i_waddr(a_wa),
        .i_wdata(a_wd), .i_raddr(a_ra), .o_rdata(aa_rd));
    mlp_ram #(.WIDTH(32), .DEPTH(ACT_SPAN)) u_bbuf (.i_clk, .i_we(ab_we), .i_waddr(a_wa),
        .i_wdata(a_wd), .i_raddr(a_ra), .o_rdata(ab_rd));

    wire lay_ok = (32'(in_ch.data.layer_sel) < MAX_LAYERS);
    wire row_ok = (32'(in_ch.data.row_sel) < ROW_SPAN);
    wire col_ok = (32'(in_ch.data.col_sel) < COL_SPAN);
    wire ni_ok  = (32'(in_ch.data.row_sel) < MAX_INPUTS);
    wire no_ok  = (32'(in_ch.data.row_sel) < MAX_OUTPUTS);

    // read-side weight address for current unit/column
    logic [63:0] w_lin, b_lin;
    always_comb begin
        w_lin = ((64'(r_layer) * 64'(ROW_SPAN)) + 64'(r_unit)) * 64'(COL_SPAN) + 64'(r_col);
        b_lin = 64'(r_layer) * 64'(ROW_SPAN) + 64'(r_unit);
    end

    logic [63:0] wl_in, bl_in;
    always_comb begin
        wl_in = ((64'(in_ch.data.layer_sel) * 64'(ROW_SPAN)) + 64'(in_ch.data.row_sel))
                * 64'(COL_SPAN) + 64'(in_ch.data.col_sel);
        bl_in = 64'(in_ch.data.layer_sel) * 64'(ROW_SPAN) + 64'(in_ch.data.row_sel);
    end

    wire last_layer = (LCW'(r_layer + LCW'(1)) == nl);
    wire signed [31:0] src_rd = r_src_b ? ab_rd : aa_rd;

    // tanh of r_res (working format) in one step
    logic signed [31:0] tanh_y;
    always_comb begin
        logic        neg;
        logic [32:0] m;
        logic [63:0] q, y, f, d;
        logic [4:0]  idx;
        neg = r_res[31];
        m = neg ? 33'(-{r_res[31], r_res}) : {1'b0, r_res};
        q = (FRAC_BITS >= 16) ? (64'(m) >> (FRAC_BITS - 16)) << 0
                              : (64'(m) << (16 - FRAC_BITS));
        f = '0;
        d = '0;
        if ((q >> 14) >= 64'd16) begin
            idx = 5'd16;
            y = 64'(tanh_point(5'd16));
        end else begin
            idx = 5'(q >> 14);
            f = q & 64'h3FFF;
            d = 64'(tanh_point(5'(idx + 5'd1))) - 64'(tanh_point(idx));
            y = 64'(tanh_point(idx)) + ((d * f) >> 14);
        end
        y = (FRAC_BITS >= 16) ? (y << (FRAC_BITS - 16)) : (y >> (16 - FRAC_BITS));
        tanh_y = neg ? -(y[31:0]) : y[31:0];
    end

    function automatic logic signed [63:0] fshift(input logic signed [63:0] v);
        return v >>> FRAC_BITS;
    endfunction

    always_comb begin
        w_we = 1'b0; b_we = 1'b0; n_we = 1'b0; rg_we = 1'b0;
        w_wa = wl_in[WAW-1:0]; b_wa = bl_in[BAW-1:0];
        n_wa = NW'(in_ch.data.row_sel); rg_wa = OW'(in_ch.data.row_sel);
        if (in_acc) begin
            case (a_act)
                ACT_WEIGHT:   w_we = lay_ok && row_ok && col_ok;
                ACT_BIAS:     b_we = lay_ok && row_ok;
                ACT_IN_NORM:  n_we = ni_ok;
                ACT_OUT_NORM: begin
                    n_we = no_ok;
                    n_wa = NW'(32'(in_ch.data.row_sel) + MAX_INPUTS);
                end
                ACT_RANGE:    rg_we = no_ok;
                default: ;
            endcase
        end
        w_ra = w_lin[WAW-1:0];
        b_ra = b_lin[BAW-1:0];
        n_ra = (r_state == S_SRD || r_state == S_IDLE) ? NW'(r_sample_count)
                                                        : NW'(32'(r_unit) + MAX_INPUTS);
        rg_ra = OW'(r_unit);
        a_ra = AW'(r_col);
        aa_we = 1'b0; ab_we = 1'b0;
        a_wa = AW'(r_unit);
        a_wd = r_res;
        if (r_state == S_SWR) begin
            // drop samples past the input count
            aa_we = (r_sample_count < ni);
            a_wa = AW'(r_sample_count);
            a_wd = r_v;
        end else if (r_state == S_ACT && !last_layer) begin
            a_wd = r_res[31] ? 32'sd0 : r_res;
            aa_we = r_src_b;
            ab_we = !r_src_b;
        end else if (r_state == S_ACT) begin
            a_wd = tanh_y;
            aa_we = r_src_b;
            ab_we = !r_src_b;
        end
    end

    wire signed [31:0] n_mean = n_rd[63:32];
    wire signed [31:0] n_dev  = n_rd[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sample_count <= '0;
            r_out_valid <= 1'b0;
            r_mac_v <= 1'b0;
            r_mac_v2 <= 1'b0;
        end else begin
            r_mac_v <= 1'b0;
            r_mac_v2 <= r_mac_v;
            if (r_mac_v2) r_acc <= sat_add64(r_acc, r_prod);
            if (r_mac_v) r_prod <= $signed(w_rd) * src_rd;
            if (out_acc) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (in_acc && a_act == ACT_SAMPLE) begin
                    r_item <= in_ch.data;
                    r_state <= S_SRD;
                end
                S_SRD: r_state <= S_SSUB;   // norm entry read this cycle
                S_SSUB: begin
                    r_span <= sat64to32(64'(r_item.value) - 64'(n_mean));
                    r_res <= n_dev;
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    r_v <= sat64to32(fshift(64'(r_span) * 64'(r_res)));
                    r_state <= S_SWR;
                end
                S_SWR: begin
                    if (r_item.sample_last) begin
                        r_sample_count <= '0;
                        r_layer <= '0;
                        r_unit <= '0;
                        r_col <= '0;
                        r_src_b <= 1'b0;
                        r_n_in <= ni;
                        r_n_out <= (nl == LCW'(1)) ? no : nh;
                        r_acc <= '0;
                        r_state <= S_MAC;
                    end else begin
                        if (r_sample_count < ni) r_sample_count <= r_sample_count + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_MAC: begin
                    r_mac_v <= 1'b1;
                    if (r_col + 1'b1 == r_n_in) r_state <= S_MDRAIN;
                    else r_col <= r_col + 1'b1;
                end
                S_MDRAIN: if (!r_mac_v && !r_mac_v2) r_state <= S_BIAS;
                S_BIAS: begin
                    r_res <= sat64to32(fshift(sat_add64(r_acc,
                                 64'($signed(b_rd)) <<< FRAC_BITS)));
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    r_acc <= '0;
                    r_col <= '0;
                    if (r_unit + 1'b1 == r_n_out) begin
                        r_unit <= '0;
                        r_src_b <= !r_src_b;
                        if (last_layer) r_state <= S_ORD;
                        else begin
                            r_layer <= r_layer + 1'b1;
                            r_n_in <= r_n_out;
                            r_n_out <= (LCW'(r_layer + LCW'(2)) == nl) ? no : nh;
                            r_state <= S_MAC;
                        end
                    end else begin
                        r_unit <= r_unit + 1'b1;
                        r_state <= S_MAC;
                    end
                end
                S_ORD: if (!r_out_valid) r_state <= S_OSPAN;  // src/range/norm read
                S_OSPAN: begin
                    r_res <= src_rd;
                    r_span <= sat64to32(64'($signed(rg_rd[31:0])) -
                                        64'($signed(rg_rd[63:32])));
                    r_wide <= 64'($signed(rg_rd[63:32]));
                    r_state <= S_OMUL1;
                end
                S_OMUL1: begin
                    r_v <= sat64to32(sat_add64(fshift(
                        ((64'(r_res) >>> 1) + (64'sd1 <<< (FRAC_BITS - 1)))
                        * (64'($signed(rg_rd[31:0])) - r_wide)), r_wide));
                    r_state <= S_OMUL2;
                end
                S_OMUL2: begin
                    r_v <= sat64to32(64'(sat64to32(fshift(64'(r_v) * 64'(n_dev))))
                                     + 64'(n_mean));
                    r_state <= S_OSEND;
                end
                S_OSEND: begin
                    r_out_valid <= 1'b1;
                    r_out.out_index <= 3'(r_unit);
                    r_out.out_value <= r_v;
                    r_out.out_last <= (r_unit + 1'b1 == no);
                    if (r_unit + 1'b1 == no) begin
                        r_unit <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_unit <= r_unit + 1'b1;
                        r_col <= r_col + 1'b1;
                        r_state <= S_ORD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;

    `ASSERT_IMPL(a_onehot, i_clk, i_rst_n, $onehot(r_state))
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !out_ch.ready, r_out_valid)
    `ASSERT_IMPL(a_no_in_busy, i_clk, i_rst_n, !(in_acc && r_state != S_IDLE))
endmodule
